[hw/rtl/cmwe_pkg.sv]
// ----------------------------------------------------------------------------
// cmwe_pkg
// Shared widths, codes and types of the column melt wipe engine.
// ----------------------------------------------------------------------------
package cmwe_pkg;

  // Field widths of the channels.
  localparam int MODE_W     = 2;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 11;
  localparam int DELAY_W    = 7;
  localparam int TX_W       = 9;
  localparam int TY_W       = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Fall offsets are 13-bit signed and saturate at the positive maximum.
  localparam int OFF_W   = 13;
  localparam int OFF_MAX = 4095;

  // Width that holds any column index up to the largest column count.
  localparam int IDX_CMP_W = 13;

  // Parameter defaults.
  localparam int MAX_COLUMNS_DEF = 2048;
  localparam int MELT_STEP_DEF   = 8;
  localparam int TEX_WIDTH_DEF   = 320;
  localparam int TEX_HEIGHT_DEF  = 200;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 11'd320;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 11'd200;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hw/rtl/cmwe_in_if.sv]
// ----------------------------------------------------------------------------
// cmwe_in_if
// Input item channel: valid/ready handshake with mode, column, row and delay.
// ----------------------------------------------------------------------------
interface cmwe_in_if;
  logic                          valid;
  logic                          ready;
  logic [cmwe_pkg::MODE_W-1:0]   mode;
  logic [cmwe_pkg::COL_W-1:0]    column;
  logic [cmwe_pkg::ROW_W-1:0]    row;
  logic [cmwe_pkg::DELAY_W-1:0]  delay;

  modport source (output valid, output mode, output column, output row, output delay,
                  input ready);
  modport sink   (input valid, input mode, input column, input row, input delay,
                  output ready);
endinterface

[hw/rtl/cmwe_out_if.sv]
// ----------------------------------------------------------------------------
// cmwe_out_if
// Result channel: valid/ready handshake with draw flag, texel coordinates
// and melt status.
// ----------------------------------------------------------------------------
interface cmwe_out_if;
  logic                       valid;
  logic                       ready;
  logic                       draw;
  logic [cmwe_pkg::TX_W-1:0]  tex_x;
  logic [cmwe_pkg::TY_W-1:0]  tex_y;
  logic                       active;
  logic                       complete;
  logic                       show_title;

  modport source (output valid, output draw, output tex_x, output tex_y, output active,
                  output complete, output show_title, input ready);
  modport sink   (input valid, input draw, input tex_x, input tex_y, input active,
                  input complete, input show_title, output ready);
endinterface

[hw/rtl/cmwe_cfg_if.sv]
// ----------------------------------------------------------------------------
// cmwe_cfg_if
// Configuration write channel: valid/ready handshake, register index, data.
// ----------------------------------------------------------------------------
interface cmwe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cmwe_pkg::CFG_IDX_W-1:0]  index;
  logic [cmwe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/column_melt_wipe_engine.sv]
// ----------------------------------------------------------------------------
// column_melt_wipe_engine
// Screen melt wipe: per-column fall offsets, frame advance and pixel lookup.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_chan (valid/ready), one result per item leaves on
// out_chan, and the screen size is written on cfg_chan, which is always ready
// and must only be written while the engine is idle.
// A load item arms the melt and stores one column's start delay. A frame tick
// walks the columns in use through the offset RAM, one column per cycle. A
// pixel query reads the column offset and, when the pixel is drawn, runs the
// shared one-bit-per-cycle divider twice (horizontal, then vertical scaling).
// One item is worked on at a time; in_chan.ready is high only while idle.
// After reset the offset RAM is cleared one entry per cycle before the first
// item is taken. A finished result waits in the output register while out_chan
// is stalled; the engine still takes the next item and only holds it at
// completion until the previous transfer is done.
// ----------------------------------------------------------------------------
module column_melt_wipe_engine #(
  parameter int MAX_COLUMNS = cmwe_pkg::MAX_COLUMNS_DEF,
  parameter int MELT_STEP   = cmwe_pkg::MELT_STEP_DEF,
  parameter int TEX_WIDTH   = cmwe_pkg::TEX_WIDTH_DEF,
  parameter int TEX_HEIGHT  = cmwe_pkg::TEX_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  cmwe_in_if.sink       in_chan,
  cmwe_out_if.source    out_chan,
  cmwe_cfg_if.sink      cfg_chan
);
  import cmwe_pkg::*;

  localparam int AW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
  localparam int TEX_MAX = (TEX_WIDTH > TEX_HEIGHT) ? TEX_WIDTH : TEX_HEIGHT;
  localparam int PROD_W  = COL_W + $clog2(TEX_MAX + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_QRD   = 3'd3;
  localparam logic [2:0] S_DIVX  = 3'd4;
  localparam logic [2:0] S_DIVY  = 3'd5;
  localparam logic [2:0] S_TICK  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  // Control state.
  logic [2:0]            state_r, state_nxt;
  logic [CFG_DATA_W-1:0] width_r, width_nxt;
  logic [CFG_DATA_W-1:0] height_r, height_nxt;
  logic                  running_r, running_nxt;
  logic                  finished_r, finished_nxt;
  logic                  armed_r, armed_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [AW-1:0]         clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  pend_r, pend_nxt;

  // Payload.
  logic [COL_W-1:0]      column_r, column_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [DELAY_W-1:0]    delay_r, delay_nxt;
  logic [ROW_W-1:0]      vy_r, vy_nxt;
  logic [AW-1:0]         wr_idx_r, wr_idx_nxt;
  logic                  all_done_r, all_done_nxt;
  logic                  draw_r, draw_nxt;
  logic [TX_W-1:0]       tx_r, tx_nxt;
  logic [TY_W-1:0]       ty_r, ty_nxt;
  logic                  o_draw_r, o_draw_nxt;
  logic [TX_W-1:0]       o_tx_r, o_tx_nxt;
  logic [TY_W-1:0]       o_ty_r, o_ty_nxt;
  logic                  o_active_r, o_active_nxt;
  logic                  o_complete_r, o_complete_nxt;
  logic                  o_title_r, o_title_nxt;

  // Offset RAM.
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [OFF_W-1:0]      mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [OFF_W-1:0]      mem_rdata;

  // Divider.
  logic                  div_start;
  logic [PROD_W-1:0]     div_dividend;
  logic [CFG_DATA_W-1:0] div_divisor;
  logic [PROD_W-1:0]     div_quo;
  div_stat_t             div_stat;

  // Helpers.
  logic [IDX_CMP_W-1:0]  ncol_wide;
  logic [CNT_W-1:0]      ncol;
  logic [IDX_CMP_W-1:0]  col_in_wide;
  logic [IDX_CMP_W-1:0]  col_r_wide;
  logic [OFF_W-2:0]      off_clamped;
  logic [OFF_W-2:0]      h_wide;
  logic [OFF_W-2:0]      span;
  logic [OFF_W-2:0]      vy_wide;
  logic                  pix_ok;
  logic [OFF_W:0]        sum;
  logic [OFF_W-1:0]      stepped;
  logic                  stepped_low;

  cmwe_ram #(
    .WIDTH (OFF_W),
    .DEPTH (MAX_COLUMNS),
    .AW    (AW)
  ) u_off_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cmwe_div #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR_W  (CFG_DATA_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    ncol_wide = (IDX_CMP_W'(width_r) < IDX_CMP_W'(MAX_COLUMNS)) ?
                IDX_CMP_W'(width_r) : IDX_CMP_W'(MAX_COLUMNS);
    ncol        = ncol_wide[CNT_W-1:0];
    col_in_wide = IDX_CMP_W'(in_chan.column);
    col_r_wide  = IDX_CMP_W'(column_r);

    // Pixel test on the stored offset, negative offsets count as zero.
    off_clamped = mem_rdata[OFF_W-1] ? '0 : mem_rdata[OFF_W-2:0];
    h_wide      = (OFF_W-1)'(height_r);
    span        = h_wide - off_clamped;
    vy_wide     = span - (OFF_W-1)'(row_r) - (OFF_W-1)'(1);
    pix_ok      = (off_clamped < h_wide) && ((OFF_W-1)'(row_r) < span);

    // Saturating advance of one column during a frame tick.
    sum         = {mem_rdata[OFF_W-1], mem_rdata} + (OFF_W+1)'(MELT_STEP);
    stepped     = ($signed(sum) > $signed((OFF_W+1)'(OFF_MAX))) ?
                  OFF_W'(OFF_MAX) : sum[OFF_W-1:0];
    stepped_low = $signed(stepped) < $signed(OFF_W'(height_r));
  end

  always_comb begin
    state_nxt      = state_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    running_nxt    = running_r;
    finished_nxt   = finished_r;
    armed_nxt      = armed_r;
    out_valid_nxt  = out_valid_r;
    clr_idx_nxt    = clr_idx_r;
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = pend_r;
    column_nxt     = column_r;
    row_nxt        = row_r;
    delay_nxt      = delay_r;
    vy_nxt         = vy_r;
    wr_idx_nxt     = wr_idx_r;
    all_done_nxt   = all_done_r;
    draw_nxt       = draw_r;
    tx_nxt         = tx_r;
    ty_nxt         = ty_r;
    o_draw_nxt     = o_draw_r;
    o_tx_nxt       = o_tx_r;
    o_ty_nxt       = o_ty_r;
    o_active_nxt   = o_active_r;
    o_complete_nxt = o_complete_r;
    o_title_nxt    = o_title_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = rd_idx_r[AW-1:0];
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = width_r;
    in_chan.ready  = 1'b0;

    if (cfg_chan.valid) begin
      if (cfg_chan.index == REG_SCREEN_WIDTH) begin
        width_nxt = cfg_chan.data;
      end else if (cfg_chan.index == REG_SCREEN_HEIGHT) begin
        height_nxt = cfg_chan.data;
      end
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(MAX_COLUMNS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_chan.ready = 1'b1;
        mem_raddr     = col_in_wide[AW-1:0];
        if (in_chan.valid) begin
          column_nxt = in_chan.column;
          row_nxt    = in_chan.row;
          delay_nxt  = in_chan.delay;
          draw_nxt   = 1'b0;
          tx_nxt     = '0;
          ty_nxt     = '0;
          state_nxt  = S_FIN;
          case (in_chan.mode)
            MODE_LOAD: begin
              running_nxt  = 1'b1;
              finished_nxt = 1'b0;
              armed_nxt    = 1'b1;
              state_nxt    = S_LOAD;
            end
            MODE_TICK: begin
              if (running_r && (width_r != '0)) begin
                rd_idx_nxt   = '0;
                pend_nxt     = 1'b0;
                all_done_nxt = 1'b1;
                state_nxt    = S_TICK;
              end
            end
            MODE_QUERY: begin
              if (running_r && (col_in_wide < ncol_wide)) begin
                state_nxt = S_QRD;
              end
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_LOAD: begin
        if (col_r_wide < IDX_CMP_W'(MAX_COLUMNS)) begin
          mem_we    = 1'b1;
          mem_waddr = col_r_wide[AW-1:0];
          mem_wdata = OFF_W'(0) - OFF_W'(delay_r);
        end
        state_nxt = S_FIN;
      end
      S_QRD: begin
        if (pix_ok) begin
          vy_nxt       = vy_wide[ROW_W-1:0];
          div_start    = 1'b1;
          div_dividend = PROD_W'(column_r) * PROD_W'(TEX_WIDTH);
          div_divisor  = width_r;
          state_nxt    = S_DIVX;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIVX: begin
        if (div_stat.done) begin
          tx_nxt = (div_quo > PROD_W'(TEX_WIDTH - 1)) ?
                   TX_W'(TEX_WIDTH - 1) : div_quo[TX_W-1:0];
          div_start    = 1'b1;
          div_dividend = PROD_W'(vy_r) * PROD_W'(TEX_HEIGHT);
          div_divisor  = height_r;
          state_nxt    = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_stat.done) begin
          ty_nxt = (div_quo > PROD_W'(TEX_HEIGHT - 1)) ?
                   TY_W'(TEX_HEIGHT - 1) : div_quo[TY_W-1:0];
          draw_nxt  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_TICK: begin
        // Read one column ahead while the previous one is written back.
        if (rd_idx_r != ncol) begin
          pend_nxt   = 1'b1;
          wr_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_r;
          mem_wdata = stepped;
          if (stepped_low) begin
            all_done_nxt = 1'b0;
          end
        end
        if ((rd_idx_r == ncol) && !pend_r) begin
          if (all_done_r) begin
            running_nxt  = 1'b0;
            finished_nxt = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          o_draw_nxt     = draw_r;
          o_tx_nxt       = tx_r;
          o_ty_nxt       = ty_r;
          o_active_nxt   = running_r;
          o_complete_nxt = finished_r;
          o_title_nxt    = !armed_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      width_r     <= SCREEN_WIDTH_RST;
      height_r    <= SCREEN_HEIGHT_RST;
      running_r   <= 1'b0;
      finished_r  <= 1'b0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
      clr_idx_r   <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      running_r   <= running_nxt;
      finished_r  <= finished_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
      clr_idx_r   <= clr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    column_r     <= column_nxt;
    row_r        <= row_nxt;
    delay_r      <= delay_nxt;
    vy_r         <= vy_nxt;
    wr_idx_r     <= wr_idx_nxt;
    all_done_r   <= all_done_nxt;
    draw_r       <= draw_nxt;
    tx_r         <= tx_nxt;
    ty_r         <= ty_nxt;
    o_draw_r     <= o_draw_nxt;
    o_tx_r       <= o_tx_nxt;
    o_ty_r       <= o_ty_nxt;
    o_active_r   <= o_active_nxt;
    o_complete_r <= o_complete_nxt;
    o_title_r    <= o_title_nxt;
  end

  assign cfg_chan.ready      = 1'b1;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.draw       = o_draw_r;
  assign out_chan.tex_x      = o_tx_r;
  assign out_chan.tex_y      = o_ty_r;
  assign out_chan.active     = o_active_r;
  assign out_chan.complete   = o_complete_r;
  assign out_chan.show_title = o_title_r;

  // The melt is never running and complete at the same time.
  a_run_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(running_r && finished_r))
    else $error("running and finished both set");

  // Until the first load, neither running nor finished can be set.
  a_title_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> (!running_r && !finished_r))
    else $error("melt state set before any load");

  // A load transfer arms the melt on the next cycle.
  a_load_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.mode == MODE_LOAD))
      |=> (running_r && armed_r && !finished_r))
    else $error("load did not arm the melt");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // No input transfer while the offset RAM is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_chan.ready)
    else $error("input taken during RAM clear");

endmodule

[hw/rtl/cmwe_ram.sv]
// ----------------------------------------------------------------------------
// cmwe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cmwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/cmwe_div.sv]
// ----------------------------------------------------------------------------
// cmwe_div
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module cmwe_div #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DIVIDEND_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0]    divisor,
  output logic [DIVIDEND_W-1:0]   quotient,
  output cmwe_pkg::div_stat_t     stat
);
  import cmwe_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it fits its width.
      rem_nxt = ge ? DIVISOR_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIVISOR_W-1:0];
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[sim/column_melt_wipe_engine_test.sv]
// ----------------------------------------------------------------------------
// column_melt_wipe_engine_test
// Self-checking bench for the screen melt wipe engine. Items are fed over the
// input channel from a queue, every accepted item is run through a local
// model of the column offsets and melt flags, and each result transfer is
// compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module column_melt_wipe_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cmwe_pkg::*;

  localparam int MAX_COLS    = MAX_COLUMNS_DEF;
  localparam int STEP        = MELT_STEP_DEF;
  localparam int TEX_W       = TEX_WIDTH_DEF;
  localparam int TEX_H       = TEX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int LONG_STALL  = 400;
  localparam int END_SETTLE  = 100;

  // Mode 3 carries no operation; the engine must leave its state alone.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [DELAY_W-1:0] delay;
  } melt_item_t;

  typedef struct packed {
    logic            draw;
    logic [TX_W-1:0] tex_x;
    logic [TY_W-1:0] tex_y;
    logic            active;
    logic            complete;
    logic            show_title;
  } melt_result_t;

  logic clk;
  logic rst_n;

  cmwe_in_if  in_chan ();
  cmwe_out_if out_chan ();
  cmwe_cfg_if cfg_chan ();

  column_melt_wipe_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Local copy of the engine state.
  logic signed [OFF_W-1:0] col_offset [MAX_COLS];
  logic                    melt_running = 1'b0;
  logic                    melt_finished = 1'b0;
  logic                    melt_armed = 1'b0;
  logic [CFG_DATA_W-1:0]   scr_width = SCREEN_WIDTH_RST;
  logic [CFG_DATA_W-1:0]   scr_height = SCREEN_HEIGHT_RST;

  melt_item_t   stim_items [$];
  melt_result_t pending_results [$];

  int items_queued = 0;
  int items_accepted = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 45;
  int stalls_asked = 0;
  int stalls_served = 0;
  int stall_left = 0;
  int n_loads = 0;
  int n_ticks = 0;
  int n_queries = 0;
  int n_drawn = 0;
  int n_complete = 0;
  logic in_accepted = 1'b0;

  initial begin
    for (int c = 0; c < MAX_COLS; c++) col_offset[c] = '0;
  end

  function automatic melt_result_t melt_predict(melt_item_t it);
    melt_result_t r;
    int cols, h, off, nxt, vy, ux, uy;
    bit all_fallen;
    r = '0;
    cols = (int'(scr_width) < MAX_COLS) ? int'(scr_width) : MAX_COLS;
    h = int'(scr_height);
    case (it.mode)
      MODE_LOAD: begin
        melt_running = 1'b1;
        melt_finished = 1'b0;
        melt_armed = 1'b1;
        if (int'(it.column) < MAX_COLS) col_offset[it.column] = -$signed({6'b0, it.delay});
      end
      MODE_TICK: begin
        if (melt_running && scr_width != '0) begin
          all_fallen = 1'b1;
          for (int c = 0; c < cols; c++) begin
            nxt = int'(col_offset[c]) + STEP;
            if (nxt > OFF_MAX) nxt = OFF_MAX;
            col_offset[c] = OFF_W'(nxt);
            if (nxt < h) all_fallen = 1'b0;
          end
          if (all_fallen) begin
            melt_running = 1'b0;
            melt_finished = 1'b1;
          end
        end
      end
      MODE_QUERY: begin
        if (melt_running && int'(it.column) < cols) begin
          off = int'(col_offset[it.column]);
          if (off < 0) off = 0;
          if (off < h && int'(it.row) < h - off) begin
            ux = int'(it.column) * TEX_W / int'(scr_width);
            vy = h - 1 - int'(it.row) - off;
            uy = vy * TEX_H / h;
            if (ux > TEX_W - 1) ux = TEX_W - 1;
            if (uy > TEX_H - 1) uy = TEX_H - 1;
            r.draw = 1'b1;
            r.tex_x = TX_W'(ux);
            r.tex_y = TY_W'(uy);
          end
        end
      end
      default: ;
    endcase
    r.active = melt_running;
    r.complete = melt_finished;
    r.show_title = !melt_armed;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Scoreboard: register writes, result checks, then prediction of new items.
  always @(posedge clk) begin
    melt_result_t got;
    melt_result_t want;
    melt_item_t it;
    in_accepted <= in_chan.valid && in_chan.ready;
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == REG_SCREEN_WIDTH) scr_width = cfg_chan.data;
        else scr_height = cfg_chan.data;
        reg_writes++;
      end
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.draw, out_chan.tex_x, out_chan.tex_y, out_chan.active,
                out_chan.complete, out_chan.show_title};
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %p", $time, got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("draw", want.draw, got.draw);
          check_field("tex_x", want.tex_x, got.tex_x);
          check_field("tex_y", want.tex_y, got.tex_y);
          check_field("active", want.active, got.active);
          check_field("complete", want.complete, got.complete);
          check_field("show_title", want.show_title, got.show_title);
          if (got.draw) n_drawn++;
          if (got.complete) n_complete++;
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        it = '{in_chan.mode, in_chan.column, in_chan.row, in_chan.delay};
        case (it.mode)
          MODE_LOAD:  n_loads++;
          MODE_TICK:  n_ticks++;
          MODE_QUERY: n_queries++;
          default: ;
        endcase
        pending_results.push_back(melt_predict(it));
        items_accepted++;
      end
    end
  end

  // Input driver: holds an item until its transfer, then maybe idles.
  always @(negedge clk) begin
    melt_item_t nxt;
    if (!in_chan.valid || in_accepted) begin
      if (stim_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = stim_items.pop_front();
        in_chan.valid  <= 1'b1;
        in_chan.mode   <= nxt.mode;
        in_chan.column <= nxt.column;
        in_chan.row    <= nxt.row;
        in_chan.delay  <= nxt.delay;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and occasional long hold-offs.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_served != stalls_asked) begin
      stalls_served <= stalls_asked;
      stall_left <= LONG_STALL;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_item(input logic [MODE_W-1:0] mode, input int column, input int row,
                            input int delay);
    stim_items.push_back('{mode, COL_W'(column), ROW_W'(row), DELAY_W'(delay)});
    items_queued++;
  endtask

  // Returns once every queued item has been accepted and every result seen.
  task automatic drain();
    while (items_accepted != items_queued || pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    int seen;
    seen = reg_writes;
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= CFG_DATA_W'(value);
    while (reg_writes == seen) @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic set_screen(input int w, input int h);
    drain();
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
  endtask

  // Mixed traffic on a configured screen: mostly queries, some ticks, reloads and unused-mode items.
  task automatic queue_melt_burst(input int count, input int w, input int h);
    int made, pick, col, row, tick_pct;
    tick_pct = (w > 64) ? 8 : 20;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      col = ($urandom_range(9) == 0) ? $urandom_range(0, 1919) : $urandom_range(0, w - 1);
      row = ($urandom_range(4) == 0) ? $urandom_range(0, 2046) : $urandom_range(0, h - 1);
      if (pick < tick_pct) begin
        queue_item(MODE_TICK, col, row, $urandom_range(0, 99));
        made++;
      end else if (pick < tick_pct + 12) begin
        queue_item(MODE_LOAD, col, row, $urandom_range(0, 99));
        made++;
      end else if (pick < tick_pct + 17) begin
        queue_item(MODE_UNUSED, col, row, $urandom_range(0, 99));
      end else begin
        queue_item(MODE_QUERY, col, row, $urandom_range(0, 99));
        made++;
      end
    end
  endtask

  initial begin
    int w, h, cols_armed;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.mode = MODE_LOAD;
    in_chan.column = '0;
    in_chan.row = '0;
    in_chan.delay = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = REG_SCREEN_WIDTH;
    cfg_chan.data = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset screen size of 320 by 200.
    queue_item(MODE_QUERY, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_UNUSED, 1919, 2046, 99);
    queue_item(MODE_LOAD, 0, 0, 0);
    queue_item(MODE_LOAD, 319, 0, 99);
    queue_item(MODE_LOAD, 1919, 0, 99);
    queue_item(MODE_QUERY, 0, 0, 0);
    queue_item(MODE_QUERY, 319, 199, 0);
    queue_item(MODE_QUERY, 320, 0, 0);
    queue_item(MODE_QUERY, 5, 2046, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_QUERY, 0, 192, 0);
    queue_item(MODE_QUERY, 0, 191, 0);
    queue_item(MODE_LOAD, 0, 0, 20);
    queue_item(MODE_QUERY, 0, 0, 0);

    // A 1920-column screen at the tallest height.
    set_screen(1920, 2047);
    queue_item(MODE_QUERY, 1919, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_QUERY, 1919, 2046, 0);
    queue_item(MODE_QUERY, 1024, 1024, 0);

    // Single pixel screen: the melt finishes, then a load arms it again.
    set_screen(1, 1);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_QUERY, 0, 0, 0);
    queue_item(MODE_LOAD, 0, 0, 0);

    // Zero width ignores ticks; zero height never draws and finishes at once.
    set_screen(0, 0);
    queue_item(MODE_TICK, 0, 0, 0);
    queue_item(MODE_QUERY, 0, 0, 0);
    set_screen(8, 0);
    queue_item(MODE_QUERY, 0, 0, 0);
    queue_item(MODE_TICK, 0, 0, 0);

    // Random bursts: arm every column of a small screen (12 random columns of a larger one), then mixed traffic.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 45;
        recv_idle_pct = 20;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      w = ($urandom_range(3) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
      h = ($urandom_range(3) == 0) ? $urandom_range(150, 2047) : $urandom_range(1, 48);
      if (p == 0) begin
        w = 320;
        h = 200;
      end
      set_screen(w, h);
      cols_armed = (w <= 24) ? w : 12;
      for (int c = 0; c < cols_armed; c++)
        queue_item(MODE_LOAD, (w <= 24) ? c : $urandom_range(0, w - 1), 0, $urandom_range(0, 99));
      if (p == 2) begin
        // The receiver holds off while items keep coming, so the input backs up.
        queue_melt_burst(30, w, h);
        stalls_asked++;
        queue_melt_burst(60, w, h);
      end else if (p == 4) begin
        queue_melt_burst(45, w, h);
        drain();
        queue_melt_burst(45, w, h);
      end else begin
        queue_melt_burst(90 - cols_armed, w, h);
      end
    end

    // Long melt on a tall narrow screen: column 0 climbs to saturation while
    // reloads of the other columns keep the melt running.
    w = $urandom_range(2, 4);
    set_screen(w, 2047);
    queue_item(MODE_LOAD, 0, 0, 0);
    for (int c = 1; c < w; c++) queue_item(MODE_LOAD, c, 0, $urandom_range(0, 99));
    for (int i = 0; i < 600; i++) begin
      case ($urandom_range(99)) inside
        [0:89]:  queue_item(MODE_TICK, 0, 0, 0);
        [90:94]: queue_item(MODE_LOAD, $urandom_range(1, w - 1), 0, $urandom_range(0, 99));
        default: queue_item(MODE_QUERY, $urandom_range(0, w - 1), $urandom_range(0, 2046), 0);
      endcase
    end

    drain();
    repeat (END_SETTLE) @(negedge clk);
    $display("Run covered %0d loads, %0d frame ticks and %0d pixel queries (%0d drawn),",
             n_loads, n_ticks, n_queries, n_drawn);
    $display("%0d results reporting a finished melt and %0d register writes.",
             n_complete, reg_writes);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
